// File: rtl/core/eft_pkg.sv
package eft_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd30;
  localparam logic [4:0] MAX_PER_PAIR_RESET = 5'd10;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_MAX_PER_PAIR = 1'b1;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_HANDLE = 2'd1,
    CMD_CLEAN = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [15:0] pair;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] proto;
    logic [7:0] dir;
    logic [31:0] stamp;
    logic [31:0] owner;
    logic [15:0] tag;
    logic [31:0] seq;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/core/expected_flow_table.sv
// Table of expected child connections. Every command (create, handle, clean,
// none) is one item and yields one result item. A scan step reads every entry
// of the entry memory in one full pass through its single registered read
// port. A write step then writes the created entry, and a finish step loads
// the result register. The input stays stalled for the whole item and is free
// again in the cycle after the result register is loaded, while that result
// may still wait to be taken. A result that is still waiting holds the finish
// step, and with it the input. Valid bits live in flip-flops and clear at reset.
module expected_flow_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [15:0] pair_key,
  input  logic [7:0]  dir_bits,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [15:0] proto,
  input  logic [31:0] now_sec,
  input  logic [31:0] flow_id,
  input  logic [15:0] data_tag,
  input  logic        flow_has_data,
  input  logic [15:0] flow_proto_ts,
  input  logic [15:0] flow_proto_tc,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic        matched,
  output logic [15:0] proto_out,
  output logic [15:0] new_proto_ts,
  output logic [15:0] new_proto_tc,
  output logic        data_moved,
  output logic [15:0] data_tag_out,
  output logic        mark_flow
);

  localparam int D = eft_pkg::TABLE_DEPTH;
  localparam int IW = eft_pkg::IDX_W;
  localparam int CW = eft_pkg::CNT_W;

  eft_pkg::state_t state, state_next;

  logic [15:0] timeout_sec;
  logic [4:0]  max_per_pair;
  logic [31:0] next_seq;
  logic [D-1:0] vld;

  // Captured item.
  eft_pkg::cmd_t c_cmd;
  logic [15:0] c_key, c_sp, c_dp, c_proto, c_tag, c_pts, c_ptc;
  logic [7:0]  c_dir;
  logic [31:0] c_now, c_fid;
  logic        c_has;

  logic [CW-1:0] cnt;

  // Scan accumulators.
  logic [CW-1:0] n_pair;
  logic          have_old;
  logic [31:0]   old_age;
  logic [IW-1:0] old_idx;
  logic          have_free;
  logic [IW-1:0] free_idx;
  logic          m_any;
  logic [31:0]   new_age;
  logic [15:0]   new_tag;
  logic [31:0]   oldm_age;
  logic [15:0]   oldm_proto;
  logic          nz_have;
  logic [31:0]   nz_age;
  logic [15:0]   nz_proto;

  logic [eft_pkg::ENTRY_W-1:0] rdata;
  eft_pkg::entry_t e, wentry;
  logic [CW-1:0] cnt_m1;
  logic [IW-1:0] p_idx;
  logic          proc, hit, match, stale;
  logic [31:0]   age;
  logic          in_acc, cfg_wr, slot_ok, do_write, res_load;
  logic [IW-1:0] slot;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == eft_pkg::REG_MAX_PER_PAIR) ? {27'd0, max_per_pair}
                                                          : {16'd0, timeout_sec};

  assign in_stall = (state != eft_pkg::ST_IDLE);
  assign in_acc = in_valid && !in_stall;

  assign e = eft_pkg::entry_t'(rdata);
  assign cnt_m1 = cnt - 1'b1;
  assign p_idx = cnt_m1[IW-1:0];
  assign proc = (state == eft_pkg::ST_SCAN) && (cnt != '0);
  assign hit = vld[p_idx] && (e.pair == c_key);
  assign age = next_seq - e.seq;
  assign match = ((e.dir & c_dir) != 8'd0) && ((e.sport == 16'd0) || (e.sport == c_sp)) &&
                 ((e.dport == 16'd0) || (e.dport == c_dp));
  assign stale = {1'b0, c_now} > ({1'b0, e.stamp} + {17'd0, timeout_sec});

  // A pair at its limit replaces its oldest entry, else the lowest free slot is used.
  assign slot_ok = ((n_pair != '0) && (32'(n_pair) >= 32'(max_per_pair))) ? have_old
                                                                          : have_free;
  assign slot = ((n_pair != '0) && (32'(n_pair) >= 32'(max_per_pair))) ? old_idx : free_idx;
  assign do_write = (state == eft_pkg::ST_WRITE) && (c_cmd == eft_pkg::CMD_CREATE) && slot_ok;
  assign res_load = (state == eft_pkg::ST_FIN) && (!out_valid || !out_stall);

  always_comb begin
    wentry.pair = c_key;
    wentry.sport = c_sp;
    wentry.dport = c_dp;
    wentry.proto = c_proto;
    wentry.dir = c_dir;
    wentry.stamp = c_now;
    wentry.owner = c_fid;
    wentry.tag = c_tag;
    wentry.seq = next_seq;
  end

  eft_ram #(
    .WIDTH(eft_pkg::ENTRY_W),
    .DEPTH(D)
  ) u_ram (
    .clk(clk),
    .we(do_write),
    .waddr(slot),
    .wdata(wentry),
    .raddr(cnt[IW-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      eft_pkg::ST_IDLE: begin
        if (in_acc) state_next = eft_pkg::ST_SCAN;
      end
      eft_pkg::ST_SCAN: begin
        if (cnt == CW'(D)) state_next = eft_pkg::ST_WRITE;
      end
      eft_pkg::ST_WRITE: begin
        state_next = eft_pkg::ST_FIN;
      end
      eft_pkg::ST_FIN: begin
        if (res_load) state_next = eft_pkg::ST_IDLE;
      end
      default: state_next = eft_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eft_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_sec <= eft_pkg::TIMEOUT_RESET;
      max_per_pair <= eft_pkg::MAX_PER_PAIR_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == eft_pkg::REG_TIMEOUT) begin
        timeout_sec <= pwdata[15:0];
      end else begin
        max_per_pair <= pwdata[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      next_seq <= '0;
    end else begin
      if (proc && hit) begin
        if (c_cmd == eft_pkg::CMD_HANDLE && (match || stale)) vld[p_idx] <= 1'b0;
        if (c_cmd == eft_pkg::CMD_CLEAN && e.owner == c_fid) vld[p_idx] <= 1'b0;
      end
      if (do_write) begin
        vld[slot] <= 1'b1;
        next_seq <= next_seq + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      c_cmd <= eft_pkg::cmd_t'(cmd);
      c_key <= pair_key;
      c_dir <= dir_bits;
      c_sp <= src_port;
      c_dp <= dst_port;
      c_proto <= proto;
      c_now <= now_sec;
      c_fid <= flow_id;
      c_tag <= data_tag;
      c_has <= flow_has_data;
      c_pts <= flow_proto_ts;
      c_ptc <= flow_proto_tc;
      cnt <= '0;
      n_pair <= '0;
      have_old <= 1'b0;
      have_free <= 1'b0;
      m_any <= 1'b0;
      nz_have <= 1'b0;
    end else if (state == eft_pkg::ST_SCAN) begin
      cnt <= cnt + 1'b1;
      if (proc) begin
        if (!vld[p_idx] && !have_free) begin
          have_free <= 1'b1;
          free_idx <= p_idx;
        end
        if (hit) begin
          n_pair <= n_pair + 1'b1;
          // Ties in age keep index order, so the later index counts as older.
          if (!have_old || age >= old_age) begin
            have_old <= 1'b1;
            old_age <= age;
            old_idx <= p_idx;
          end
          if (match) begin
            m_any <= 1'b1;
            if (!m_any || age < new_age) begin
              new_age <= age;
              new_tag <= e.tag;
            end
            if (!m_any || age >= oldm_age) begin
              oldm_age <= age;
              oldm_proto <= e.proto;
            end
            if (e.proto != 16'd0 && (!nz_have || age < nz_age)) begin
              nz_have <= 1'b1;
              nz_age <= age;
              nz_proto <= e.proto;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status <= (c_cmd == eft_pkg::CMD_CREATE) && !slot_ok;
      mark_flow <= (c_cmd == eft_pkg::CMD_CREATE) && slot_ok;
      matched <= (c_cmd == eft_pkg::CMD_HANDLE) && m_any;
      proto_out <= ((c_cmd == eft_pkg::CMD_HANDLE) && m_any) ? oldm_proto : 16'd0;
      new_proto_ts <= ((c_cmd == eft_pkg::CMD_HANDLE) && c_pts == 16'd0 && nz_have) ?
                      nz_proto : c_pts;
      new_proto_tc <= ((c_cmd == eft_pkg::CMD_HANDLE) && c_ptc == 16'd0 && nz_have) ?
                      nz_proto : c_ptc;
      data_moved <= (c_cmd == eft_pkg::CMD_HANDLE) && m_any && !c_has;
      data_tag_out <= ((c_cmd == eft_pkg::CMD_HANDLE) && m_any && !c_has) ? new_tag : 16'd0;
    end
  end

`ifndef SYNTH
  a_acc_scan: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == eft_pkg::ST_SCAN) && (cnt == '0))
    else $error("accepted item did not start a scan");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == eft_pkg::ST_SCAN) |-> (cnt <= CW'(D)))
    else $error("scan counter ran past the table");
  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    do_write |=> (next_seq == $past(next_seq) + 32'd1))
    else $error("sequence number did not advance on create");
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == eft_pkg::ST_FIN))
    else $error("result appeared outside the finish step");
`endif

endmodule

// File: rtl/core/eft_ram.sv
module eft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
